/* design/ttsgr_pkg.sv */
// ----------------------------------------------------------------------------
// ttsgr_pkg
// Shared types, constants and color palettes of the terminal SGR engine.
// ----------------------------------------------------------------------------
package ttsgr_pkg;

  // Byte codes
  localparam logic [7:0] ChEsc    = 8'h1b;
  localparam logic [7:0] ChLbrack = 8'h5b;
  localparam logic [7:0] ChM      = 8'h6d;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam logic [7:0]  WidthReset = 8'd80;
  localparam logic [23:0] ForeReset  = 24'hf2f2f2;
  localparam logic [23:0] BackReset  = 24'h181818;

  localparam int unsigned OutW = 72;

  typedef enum logic [1:0] {
    ST_TEXT,
    ST_ESC,
    ST_CSI,
    ST_SGR
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic text;       // handle byte as normal text
    logic csi_start;  // clear parameter queue
    logic digit;      // accumulate a digit
    logic push;       // close the current parameter
    logic walk_start; // close last parameter, start the SGR walk
    logic walk_step;  // apply one parameter group
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_esc;
    logic is_lbrack;
    logic is_digit;
    logic is_semi;
    logic is_m;
    logic slot_full;
    logic walk_last;
    logic out_busy;
  } status_t;

  function automatic logic [23:0] dark_set(input logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      3'd0: c = 24'h121212;
      3'd1: c = 24'ha61010;
      3'd2: c = 24'h10a610;
      3'd3: c = 24'ha66010;
      3'd4: c = 24'h1010a6;
      3'd5: c = 24'ha610a6;
      3'd6: c = 24'h10a6a6;
      default: c = 24'ha6a6a6;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] light_set(input logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      3'd0: c = 24'h323232;
      3'd1: c = 24'hd01010;
      3'd2: c = 24'h10d010;
      3'd3: c = 24'hd0d010;
      3'd4: c = 24'h1060d0;
      3'd5: c = 24'hd010d0;
      3'd6: c = 24'h10d0d0;
      default: c = 24'hd0d0d0;
    endcase
    return c;
  endfunction

endpackage

/* design/text_terminal_sgr_cursor_engine_core.sv */
// ----------------------------------------------------------------------------
// text_terminal_sgr_cursor_engine_core
// Terminal byte stream to glyph stream with cursor and SGR color tracking.
// ----------------------------------------------------------------------------
// A printable byte shows on the output in the cycle after its acceptance.
// Throughput: one byte per cycle; a final 'm' then holds the input while the
// walker applies the SGR parameter groups, one group per step.
// Input also stalls while a glyph waits and the output is not taken.
// Reset (async, low): text phase, cursor 0,0, default colors, width 80.
module text_terminal_sgr_cursor_engine_core #(
  parameter int unsigned MAX_PARAMS = 10,
  parameter int unsigned TAB_STOP   = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [7:0]                 cfg_data_i,   // line_width
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata, // byte_in
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // glyph_code[6:0], glyph_row[14:7], glyph_column[22:15],
  // fore_color[46:23], back_color[70:47], zero[71]
  output logic [ttsgr_pkg::OutW-1:0] m_axis_tdata
);
  import ttsgr_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  ttsgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttsgr_dpath #(
    .MAX_PARAMS (MAX_PARAMS),
    .TAB_STOP   (TAB_STOP)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* design/ttsgr_ctrl.sv */
// ----------------------------------------------------------------------------
// ttsgr_ctrl
// Escape phase state machine; issues commands to the datapath.
// ----------------------------------------------------------------------------
module ttsgr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ttsgr_pkg::status_t status_i,
  output ttsgr_pkg::cmd_t    cmd_o
);
  import ttsgr_pkg::*;

  state_e state_q, state_d;
  logic   fire;

  assign in_ready_o = (state_q != ST_SGR) && !status_i.out_busy;
  assign fire       = in_valid_i && in_ready_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TEXT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_TEXT: begin
        if (fire && status_i.is_esc) state_d = ST_ESC;
      end
      ST_ESC: begin
        if (fire) begin
          if (status_i.is_lbrack)   state_d = ST_CSI;
          else if (status_i.is_esc) state_d = ST_ESC;
          else                      state_d = ST_TEXT;
        end
      end
      ST_CSI: begin
        if (fire) begin
          if (status_i.is_digit)     state_d = ST_CSI;
          else if (status_i.is_semi) state_d = status_i.slot_full ? ST_TEXT : ST_CSI;
          else if (status_i.is_m)    state_d = ST_SGR;
          else                       state_d = ST_TEXT;
        end
      end
      ST_SGR: begin
        if (status_i.walk_last) state_d = ST_TEXT;
      end
      default: state_d = ST_TEXT;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_TEXT: cmd_o.text = fire;
      ST_ESC: begin
        cmd_o.csi_start = fire && status_i.is_lbrack;
        cmd_o.text      = fire && !status_i.is_lbrack;
      end
      ST_CSI: begin
        cmd_o.digit      = fire && status_i.is_digit;
        cmd_o.push       = fire && status_i.is_semi && !status_i.slot_full;
        cmd_o.walk_start = fire && status_i.is_m;
      end
      ST_SGR: cmd_o.walk_step = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* design/ttsgr_dpath.sv */
// ----------------------------------------------------------------------------
// ttsgr_dpath
// Cursor, colors, parameter queue, SGR walker and output register.
// ----------------------------------------------------------------------------
module ttsgr_dpath #(
  parameter int unsigned MAX_PARAMS = 10,
  parameter int unsigned TAB_STOP   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [7:0]                  byte_i,
  input  logic                        cfg_we_i,
  input  logic [7:0]                  cfg_data_i,
  input  ttsgr_pkg::cmd_t              cmd_i,
  output ttsgr_pkg::status_t           status_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ttsgr_pkg::OutW-1:0]  out_data_o
);
  import ttsgr_pkg::*;

  localparam int unsigned IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int unsigned CW = $clog2(MAX_PARAMS + 1);
  localparam int unsigned MW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam logic [MW-1:0] ModLast = MW'(TAB_STOP - 1);
  localparam logic [MW-1:0] ModSat  = MW'(255 % TAB_STOP);
  localparam logic [8:0]    TabW    = 9'(TAB_STOP);

  logic [7:0]    width_q;
  logic [7:0]    row_q, col_q;
  logic [MW-1:0] mod_q;
  logic [23:0]   fore_q, back_q;
  logic [15:0]   acc_q;
  logic [15:0]   par_q [MAX_PARAMS];
  logic [IW-1:0] slot_q;
  logic [CW-1:0] cnt_q;
  logic          out_valid_q;
  logic [OutW-1:0] out_data_q;

  // Byte classes
  assign status_o.is_esc    = (byte_i == ChEsc);
  assign status_o.is_lbrack = (byte_i == ChLbrack);
  assign status_o.is_digit  = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign status_o.is_semi   = (byte_i == ChSemi);
  assign status_o.is_m      = (byte_i == ChM);
  assign status_o.slot_full = (slot_q == IW'(MAX_PARAMS - 1));
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_data_i;
    end
  end

  // Text handling: cursor next values and glyph
  logic          printable, emit;
  logic [7:0]    row_w, col_w, row_n, col_n;
  logic [MW-1:0] mod_w, mod_n;
  logic [8:0]    tab_sum;

  always_comb begin
    printable = (byte_i >= ChSpace) && !byte_i[7];
    emit      = cmd_i.text && printable;
    row_w = row_q;
    col_w = col_q;
    mod_w = mod_q;
    if (col_q >= width_q) begin
      row_w = row_q + 8'd1;
      col_w = '0;
      mod_w = '0;
    end
    tab_sum = {1'b0, col_q} + TabW - {{(9 - MW){1'b0}}, mod_q};
    row_n = row_q;
    col_n = col_q;
    mod_n = mod_q;
    if (cmd_i.text) begin
      if (printable) begin
        row_n = row_w;
        col_n = col_w;
        mod_n = mod_w;
        if (col_w != 8'hff) begin
          col_n = col_w + 8'd1;
          mod_n = (mod_w == ModLast) ? '0 : mod_w + MW'(1);
        end
      end else if (byte_i == ChLf || byte_i == ChCr) begin
        row_n = row_q + 8'd1;
        col_n = '0;
        mod_n = '0;
      end else if (byte_i == ChTab) begin
        if (tab_sum > 9'd255) begin
          col_n = 8'hff;
          mod_n = ModSat;
        end else begin
          col_n = tab_sum[7:0];
          mod_n = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      mod_q <= '0;
    end else begin
      row_q <= row_n;
      col_q <= col_n;
      mod_q <= mod_n;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {1'b0, back_q, fore_q, col_w, row_w, byte_i[6:0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Parameter accumulator and queue
  logic [15:0] acc_x10;
  assign acc_x10 = (acc_q << 3) + (acc_q << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      slot_q <= '0;
    end else if (cmd_i.csi_start) begin
      acc_q  <= '0;
      slot_q <= '0;
    end else if (cmd_i.digit) begin
      acc_q <= acc_x10 + {12'd0, byte_i[3:0]};
    end else if (cmd_i.push) begin
      acc_q  <= '0;
      slot_q <= slot_q + IW'(1);
    end
  end

  // SGR walker on the queue head
  logic [15:0] v;
  logic [2:0]  shift;
  logic [23:0] fore_n, back_n, pick;
  logic        hit;

  always_comb begin
    v      = par_q[0];
    shift  = 3'd1;
    fore_n = fore_q;
    back_n = back_q;
    hit    = 1'b0;
    pick   = '0;
    if (v == 16'd0) begin
      fore_n = dark_set(3'd7);
      back_n = dark_set(3'd0);
    end else if (v == 16'd7) begin
      fore_n = back_q;
      back_n = fore_q;
    end else if (v >= 16'd30 && v <= 16'd37) begin
      fore_n = dark_set(v[2:0] - 3'd6);
    end else if (v == 16'd38 || v == 16'd48) begin
      if (cnt_q > CW'(2) && par_q[1] == 16'd5) begin
        pick  = dark_set(par_q[2][2:0]);
        shift = 3'd3;
        hit   = 1'b1;
      end else if (cnt_q > CW'(4) && par_q[1] == 16'd2) begin
        pick  = {par_q[2][7:0], par_q[3][7:0], par_q[4][7:0]};
        shift = 3'd5;
        hit   = 1'b1;
      end
      if (hit) begin
        if (v == 16'd38) fore_n = pick;
        else             back_n = pick;
      end
    end else if (v == 16'd39) begin
      fore_n = dark_set(3'd7);
    end else if (v >= 16'd40 && v <= 16'd47) begin
      back_n = dark_set(v[2:0]);
    end else if (v == 16'd49) begin
      back_n = dark_set(3'd0);
    end else if (v >= 16'd90 && v <= 16'd97) begin
      light_pick: fore_n = light_set(v[2:0] - 3'd2);
    end else if (v >= 16'd100 && v <= 16'd107) begin
      back_n = light_set(v[2:0] - 3'd4);
    end
  end

  assign status_o.walk_last = (cnt_q <= CW'(shift));

  // Colors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q <= ForeReset;
      back_q <= BackReset;
    end else if (cmd_i.walk_step) begin
      fore_q <= fore_n;
      back_q <= back_n;
    end
  end

  // Walk count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.walk_start) begin
      cnt_q <= CW'(slot_q) + CW'(1);
    end else if (cmd_i.walk_step) begin
      cnt_q <= status_o.walk_last ? '0 : cnt_q - CW'(shift);
    end
  end

  // Queue storage: write at slot, shift toward head while walking
  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.walk_start) begin
      par_q[slot_q] <= acc_q;
    end else if (cmd_i.walk_step) begin
      for (int k = 0; k < MAX_PARAMS; k++) begin
        if (shift == 3'd1) begin
          if (k + 1 < MAX_PARAMS) par_q[k] <= par_q[k+1];
        end else if (shift == 3'd3) begin
          if (k + 3 < MAX_PARAMS) par_q[k] <= par_q[k+3];
        end else begin
          if (k + 5 < MAX_PARAMS) par_q[k] <= par_q[k+5];
        end
      end
    end
  end

endmodule

/* design/ttsgr_checker.sv */
// ----------------------------------------------------------------------------
// ttsgr_checker
// Port-level checks of the terminal SGR engine, bound to the top level.
// ----------------------------------------------------------------------------
module ttsgr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // Stalled glyph stays valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("glyph dropped while stalled");

  // Stalled glyph keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("glyph changed while stalled");

  // A new glyph follows an input transaction
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready) |->
      $past(s_axis_tvalid && s_axis_tready))
    else $error("glyph without input transaction");

  // Glyphs are printable codes with a clear pad bit
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:5] != 2'b00) && !m_axis_tdata[71])
    else $error("bad glyph code");

endmodule

bind text_terminal_sgr_cursor_engine_core ttsgr_checker u_ttsgr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/tb_text_terminal_sgr_cursor_engine_core.sv */
// ----------------------------------------------------------------------------
// tb_text_terminal_sgr_cursor_engine_core
// Drives terminal bytes (text, controls, SGR escape sequences) into the engine
// and checks every glyph against an in-bench model of cursor and color state.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_text_terminal_sgr_cursor_engine_core;
  import ttsgr_pkg::*;

  localparam int NPARAM = 10;
  localparam int TABW   = 8;

  typedef struct packed {
    logic [23:0] back;
    logic [23:0] fore;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [6:0]  code;
  } glyph_t;

  typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_CSI} phase_e;

  // Directed stimulus row: byte, and an optional typed-in expected glyph
  typedef struct {
    logic [7:0] b;
    bit         has_exp;
    glyph_t     g;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // byte_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // glyph_code, glyph_row, glyph_column, fore_color, back_color, zero pad
  logic [OutW-1:0] m_axis_tdata;

  text_terminal_sgr_cursor_engine_core u_dut (.*);

  always #4 clk_i = ~clk_i;

  // Model state
  logic [7:0]  width_q;
  phase_e      phase_q;
  logic [15:0] params_q [NPARAM];
  int          slot_q;
  logic [23:0] fore_q, back_q;
  logic [7:0]  row_q, col_q;

  glyph_t glyphs_pending[$];
  int     n_mismatch = 0;
  bit     calm = 0;      // no idling on either side

  function automatic logic [23:0] dark_c(int i);
    logic [23:0] t [8] = '{24'h121212, 24'ha61010, 24'h10a610, 24'ha66010,
                           24'h1010a6, 24'ha610a6, 24'h10a6a6, 24'ha6a6a6};
    return t[i & 7];
  endfunction

  function automatic logic [23:0] light_c(int i);
    logic [23:0] t [8] = '{24'h323232, 24'hd01010, 24'h10d010, 24'hd0d010,
                           24'h1060d0, 24'hd010d0, 24'h10d0d0, 24'hd0d0d0};
    return t[i & 7];
  endfunction

  task automatic apply_colors();
    int cnt;
    int v;
    logic [23:0] c;
    bit hit;
    cnt = slot_q + 1;
    if (cnt > NPARAM) cnt = NPARAM;
    for (int i = 0; i < cnt; i++) begin
      v = params_q[i];
      if (v == 0) begin
        fore_q = dark_c(7);
        back_q = dark_c(0);
      end else if (v == 7) begin
        c = back_q; back_q = fore_q; fore_q = c;
      end else if (v >= 30 && v <= 37) begin
        fore_q = dark_c(v - 30);
      end else if (v == 38 || v == 48) begin
        hit = 0;
        if (i + 2 < cnt && params_q[i+1] == 5) begin
          c = dark_c(params_q[i+2] & 7);
          i += 2; hit = 1;
        end else if (i + 4 < cnt && params_q[i+1] == 2) begin
          c = {params_q[i+2][7:0], params_q[i+3][7:0], params_q[i+4][7:0]};
          i += 4; hit = 1;
        end
        if (hit) begin
          if (v == 38) fore_q = c;
          else back_q = c;
        end
      end else if (v == 39) fore_q = dark_c(7);
      else if (v >= 40 && v <= 47) back_q = dark_c(v - 40);
      else if (v == 49) back_q = dark_c(0);
      else if (v >= 90 && v <= 97) fore_q = light_c(v - 90);
      else if (v >= 100 && v <= 107) back_q = light_c(v - 100);
    end
  endtask

  // Advance the model by one accepted byte; queue a glyph if one results
  task automatic predict_byte(logic [7:0] b);
    int c;
    glyph_t g;
    if (phase_q == PH_CSI) begin
      if (b >= ChZero && b <= ChNine)
        params_q[slot_q] = params_q[slot_q] * 16'd10 + 16'(b - ChZero);
      else if (b == ChSemi) begin
        if (slot_q + 1 >= NPARAM) phase_q = PH_TEXT;
        else slot_q++;
      end else begin
        if (b == ChM) apply_colors();
        phase_q = PH_TEXT;
      end
      return;
    end
    if (phase_q == PH_ESC && b == ChLbrack) begin
      foreach (params_q[i]) params_q[i] = '0;
      slot_q = 0;
      phase_q = PH_CSI;
      return;
    end
    phase_q = PH_TEXT;
    if (b >= 8'h80 || b == 8'h00) return;
    if (b < ChSpace) begin
      if (b == ChLf || b == ChCr) begin
        row_q++; col_q = '0;
      end else if (b == ChTab) begin
        c = ((col_q + TABW) / TABW) * TABW;
        col_q = (c > 255) ? 8'd255 : 8'(c);
      end else if (b == ChEsc) phase_q = PH_ESC;
      return;
    end
    if (col_q >= width_q) begin
      row_q++; col_q = '0;
    end
    g.code = b[6:0];
    g.row  = row_q;
    g.col  = col_q;
    g.fore = fore_q;
    g.back = back_q;
    glyphs_pending.push_back(g);
    if (col_q != 8'd255) col_q++;
  endtask

  // Valid stays high after a transaction; the next call or the caller drops it
  task automatic send_byte(logic [7:0] b);
    while (!calm && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Write the line width once all glyphs are out and the engine is quiet
  task automatic set_width(logic [7:0] w);
    s_axis_tvalid <= 1'b0;
    while (glyphs_pending.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    width_q = w;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Output side: random stalls, compare each glyph against the oldest one
  always @(negedge clk_i)
    m_axis_tready <= calm || ($urandom_range(99) >= 21);

  always @(posedge clk_i) begin
    glyph_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[70:0];
      if (glyphs_pending.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected glyph %h", got);
      end else begin
        want = glyphs_pending.pop_front();
        if (got !== want || m_axis_tdata[71] !== 1'b0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("glyph mismatch: exp code %h row %0d col %0d fg %h bg %h / got code %h row %0d col %0d fg %h bg %h",
                     want.code, want.row, want.col, want.fore, want.back,
                     got.code, got.row, got.col, got.fore, got.back);
        end
      end
    end
  end

  // Random SGR sequence, mostly well formed
  task automatic send_sgr();
    int n;
    int k;
    string s;
    s = "\033[";
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (i) s = {s, ";"};
      k = $urandom_range(9);
      case (k)
        0: s = {s, "0"};
        1: s = {s, "7"};
        2: s = {s, $sformatf("%0d", 30 + $urandom_range(9))};
        3: s = {s, $sformatf("%0d", 40 + $urandom_range(9))};
        4: s = {s, $sformatf("%0d", 90 + $urandom_range(17))};
        5: s = {s, $sformatf("%0d;5;%0d", $urandom_range(1) ? 38 : 48, $urandom_range(300))};
        6: s = {s, $sformatf("%0d;2;%0d;%0d;%0d", $urandom_range(1) ? 38 : 48,
                             $urandom_range(999), $urandom_range(255), $urandom_range(65535))};
        7: s = {s, $sformatf("%0d", $urandom_range(99999))};
        8: s = {s, ""};
        default: s = {s, $sformatf("%0d", $urandom_range(1) ? 38 : 48)};
      endcase
    end
    case ($urandom_range(9))
      0: s = {s, ";;;;;;;;;;;1m"};     // runs past the last slot
      1: s = {s, "x"};                 // unknown final byte
      default: s = {s, "m"};
    endcase
    send_str(s);
  endtask

  task automatic send_noise(int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: b = 8'($urandom_range(255));
        1: b = ChLf;
        2: b = ChTab;
        3: b = ChEsc;
        4: b = ChCr;
        default: b = 8'($urandom_range(8'h20, 8'h7f));
      endcase
      send_byte(b);
    end
  endtask

  row_t dir_rows[$];

  function automatic row_t mk(logic [7:0] b, bit he = 0, glyph_t g = '0);
    row_t r;
    r.b = b; r.has_exp = he; r.g = g;
    return r;
  endfunction

  initial begin
    logic [7:0] widths [5] = '{8'd1, 8'd240, 8'd0, 8'd13, 8'd80};
    int sent;
    width_q = WidthReset;
    phase_q = PH_TEXT;
    foreach (params_q[i]) params_q[i] = '0;
    slot_q = 0;
    fore_q = ForeReset;
    back_q = BackReset;
    row_q = '0;
    col_q = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: extremes and reset values typed in, the rest predicted
    dir_rows.push_back(mk(ChSpace, 1, '{BackReset, ForeReset, 8'd0, 8'd0, 7'h20}));
    dir_rows.push_back(mk(8'h7f, 1, '{BackReset, ForeReset, 8'd1, 8'd0, 7'h7f}));
    dir_rows.push_back(mk(8'h00));
    dir_rows.push_back(mk(8'hff));
    dir_rows.push_back(mk(8'h80));
    dir_rows.push_back(mk(ChTab));
    dir_rows.push_back(mk(8'h41, 1, '{BackReset, ForeReset, 8'd8, 8'd0, 7'h41}));
    dir_rows.push_back(mk(ChLf));
    dir_rows.push_back(mk(ChCr));
    dir_rows.push_back(mk(ChEsc));
    dir_rows.push_back(mk(8'h42));   // ESC then non '[': byte handled as text
    dir_rows.push_back(mk(ChEsc));
    dir_rows.push_back(mk(ChLbrack));
    dir_rows.push_back(mk(ChZero));
    dir_rows.push_back(mk(ChM));
    dir_rows.push_back(mk(8'h43, 1, '{24'h121212, 24'ha6a6a6, 8'd1, 8'd2, 7'h43}));
    dir_rows.push_back(mk(8'h01));
    dir_rows.push_back(mk(8'h1f));
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b);
      if (dir_rows[i].has_exp && glyphs_pending.size() != 0)
        glyphs_pending[$] = dir_rows[i].g;
    end
    send_str("\033[7;38;2;1;2;3;48;5;13m\033[38;5m\033[999999m\033[1;2x#");
    send_str("\033[;;;;;;;;;;9m$\033[97;107m%\t\t\t\t");
    send_str("\033[30;31;32;33;34;35;36;37;39;40m*\033[49;100m+");

    // Random phases over several line widths
    sent = 0;
    foreach (widths[w]) begin
      set_width(widths[w]);
      for (int i = 0; i < 60; i++) begin
        calm = (w == 3);
        if ($urandom_range(9) < 2) send_sgr();
        else if (widths[w] == 8'd240 && $urandom_range(19) == 0)
          repeat (40) send_byte(ChTab);   // push column to saturation
        else send_noise(1);
      end
    end
    calm = 0;
    s_axis_tvalid <= 1'b0;

    while (glyphs_pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (n_mismatch == 0 && glyphs_pending.size() == 0)
      $display("** text_terminal_sgr_cursor_engine_core: PASSED **");
    else
      $display("** text_terminal_sgr_cursor_engine_core: FAILED **");
    $finish;
  end

  initial begin
    #4000000;
    $display("** text_terminal_sgr_cursor_engine_core: FAILED **");
    $finish;
  end

endmodule
